>>> rtl/core/gbl_pkg.sv
// Shared types and codes for the gap buffer line store.
// Command, status and sequencer state encodings; no dependencies.
`timescale 1ns / 1ps
`default_nettype none

package gbl_pkg;

  localparam int CMD_W  = 2;
  localparam int POS_W  = 9;
  localparam int CHAR_W = 8;
  localparam int STAT_W = 2;

  typedef enum logic [CMD_W-1:0] {
    CMD_INSERT    = 2'd0,
    CMD_BACKSPACE = 2'd1,
    CMD_READ      = 2'd2,
    CMD_CLEAR     = 2'd3
  } cmd_t;

  typedef enum logic [STAT_W-1:0] {
    ST_OK      = 2'd0,
    ST_FULL    = 2'd1,
    ST_RANGE   = 2'd2,
    ST_NOTHING = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SEEK,
    S_COPY,
    S_RDWAIT,
    S_DONE
  } state_t;

endpackage

`default_nettype wire

>>> rtl/core/gbl_ram.sv
// Text storage for the gap buffer: one write port, one registered read port.
// Uses gbl_pkg for the character width.
`timescale 1ns / 1ps
`default_nettype none

module gbl_ram
  import gbl_pkg::*;
#(
  parameter int DEPTH = 256,
  parameter int AW    = 8
) (
  input  wire logic              clk,
  input  wire logic              we,
  input  wire logic [AW-1:0]     waddr,
  input  wire logic [CHAR_W-1:0] wdata,
  input  wire logic              re,
  input  wire logic [AW-1:0]     raddr,
  output logic      [CHAR_W-1:0] rdata
);

  logic [CHAR_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

>>> rtl/core/gap_buffer_line_store.sv
// Gap buffer line store: one line of up to CAPACITY bytes held with a movable gap.
// Every request gives exactly one result. A request is taken only while the
// sequencer is idle; a finished result may still wait in the output register.
// Insert and backspace move the gap one position per step (read the byte across
// the gap from the single RAM read port in S_SEEK, then write it on the far side
// in S_COPY) until it sits at the cursor, then finish the edit. Read waits for
// the registered RAM read in S_RDWAIT. The store needs no clearing pass after
// reset: only bytes that belong to the line are ever read.
// Depends on gbl_pkg and gbl_ram.
`timescale 1ns / 1ps
`default_nettype none

module gap_buffer_line_store
  import gbl_pkg::*;
#(
  parameter int CAPACITY = 256
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire logic [CMD_W-1:0]  in_command,
  input  wire logic [POS_W-1:0]  in_position,
  input  wire logic [CHAR_W-1:0] in_char_in,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output logic [STAT_W-1:0]      out_status,
  output logic [CHAR_W-1:0]      out_char_out,
  output logic [POS_W-1:0]       out_line_length,
  output logic [POS_W-1:0]       out_gap_position
);

  localparam int LW = $clog2(CAPACITY + 1);
  localparam int AW = $clog2(CAPACITY);
  localparam int WW = ((LW > POS_W) ? LW : POS_W) + 1;
  localparam logic [LW-1:0] CAP_L = LW'(CAPACITY);
  localparam logic [WW-1:0] ONE_W = WW'(1);
  localparam logic [LW-1:0] ONE_L = LW'(1);

  state_t            state_r, state_nxt;
  logic [LW-1:0]     gs_r, gs_nxt;
  logic [LW-1:0]     gl_r, gl_nxt;
  cmd_t              cmd_r, cmd_nxt;
  logic [LW-1:0]     pos_r, pos_nxt;
  logic [CHAR_W-1:0] ch_r, ch_nxt;
  logic              dir_left_r, dir_left_nxt;
  status_t           stat_r, stat_nxt;
  logic [CHAR_W-1:0] cout_r, cout_nxt;

  logic              out_valid_r, out_valid_nxt;
  logic [STAT_W-1:0] out_status_r, out_status_nxt;
  logic [CHAR_W-1:0] out_char_r, out_char_nxt;
  logic [POS_W-1:0]  out_len_r, out_len_nxt;
  logic [POS_W-1:0]  out_gap_r, out_gap_nxt;

  logic              ram_we, ram_re;
  logic [AW-1:0]     ram_waddr, ram_raddr;
  logic [CHAR_W-1:0] ram_wdata, ram_rdata;

  logic              accept;
  logic [LW-1:0]     len_l;
  logic [WW-1:0]     pos_ext, len_ext, gs_ext, gl_ext;
  logic [WW-1:0]     rd_idx, left_src, right_src, left_dst;

  assign in_stall = (state_r != S_IDLE);
  assign accept   = in_valid && !in_stall;

  assign len_l     = CAP_L - gl_r;
  assign pos_ext   = {{(WW-POS_W){1'b0}}, in_position};
  assign len_ext   = {{(WW-LW){1'b0}}, len_l};
  assign gs_ext    = {{(WW-LW){1'b0}}, gs_r};
  assign gl_ext    = {{(WW-LW){1'b0}}, gl_r};
  // Logical index to physical slot: skip the gap when past its start.
  assign rd_idx    = (pos_ext < gs_ext) ? pos_ext : (pos_ext + gl_ext);
  assign left_src  = gs_ext - ONE_W;
  assign right_src = gs_ext + gl_ext;
  assign left_dst  = gs_ext + gl_ext - ONE_W;

  always_comb begin
    state_nxt      = state_r;
    gs_nxt         = gs_r;
    gl_nxt         = gl_r;
    cmd_nxt        = cmd_r;
    pos_nxt        = pos_r;
    ch_nxt         = ch_r;
    dir_left_nxt   = dir_left_r;
    stat_nxt       = stat_r;
    cout_nxt       = cout_r;
    out_valid_nxt  = out_valid_r && out_stall;
    out_status_nxt = out_status_r;
    out_char_nxt   = out_char_r;
    out_len_nxt    = out_len_r;
    out_gap_nxt    = out_gap_r;
    ram_we         = 1'b0;
    ram_waddr      = gs_r[AW-1:0];
    ram_wdata      = ram_rdata;
    ram_re         = 1'b0;
    ram_raddr      = rd_idx[AW-1:0];

    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          cmd_nxt  = cmd_t'(in_command);
          pos_nxt  = pos_ext[LW-1:0];
          ch_nxt   = in_char_in;
          cout_nxt = '0;
          stat_nxt = ST_OK;
          case (cmd_t'(in_command))
            CMD_INSERT: begin
              if (pos_ext > len_ext) begin
                stat_nxt  = ST_RANGE;
                state_nxt = S_DONE;
              end else if (gl_r == '0) begin
                stat_nxt  = ST_FULL;
                state_nxt = S_DONE;
              end else begin
                state_nxt = S_SEEK;
              end
            end
            CMD_BACKSPACE: begin
              if (pos_ext > len_ext) begin
                stat_nxt  = ST_RANGE;
                state_nxt = S_DONE;
              end else if (pos_ext == '0) begin
                stat_nxt  = ST_NOTHING;
                state_nxt = S_DONE;
              end else begin
                state_nxt = S_SEEK;
              end
            end
            CMD_READ: begin
              if (pos_ext >= len_ext) begin
                stat_nxt  = ST_RANGE;
                state_nxt = S_DONE;
              end else begin
                ram_re    = 1'b1;
                state_nxt = S_RDWAIT;
              end
            end
            default: begin
              gs_nxt    = '0;
              gl_nxt    = CAP_L;
              state_nxt = S_DONE;
            end
          endcase
        end
      end

      S_SEEK: begin
        if (gs_r > pos_r) begin
          ram_re       = 1'b1;
          ram_raddr    = left_src[AW-1:0];
          dir_left_nxt = 1'b1;
          state_nxt    = S_COPY;
        end else if (gs_r < pos_r) begin
          ram_re       = 1'b1;
          ram_raddr    = right_src[AW-1:0];
          dir_left_nxt = 1'b0;
          state_nxt    = S_COPY;
        end else begin
          // Gap sits at the cursor: finish the edit.
          if (cmd_r == CMD_INSERT) begin
            ram_we    = 1'b1;
            ram_waddr = gs_r[AW-1:0];
            ram_wdata = ch_r;
            gs_nxt    = gs_r + ONE_L;
            gl_nxt    = gl_r - ONE_L;
          end else begin
            gs_nxt    = gs_r - ONE_L;
            gl_nxt    = gl_r + ONE_L;
          end
          state_nxt = S_DONE;
        end
      end

      S_COPY: begin
        ram_we = 1'b1;
        if (dir_left_r) begin
          ram_waddr = left_dst[AW-1:0];
          gs_nxt    = gs_r - ONE_L;
        end else begin
          ram_waddr = gs_r[AW-1:0];
          gs_nxt    = gs_r + ONE_L;
        end
        state_nxt = S_SEEK;
      end

      S_RDWAIT: begin
        cout_nxt  = ram_rdata;
        state_nxt = S_DONE;
      end

      S_DONE: begin
        // Hold until the previous result has been taken.
        if (!(out_valid_r && out_stall)) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = stat_r;
          out_char_nxt   = cout_r;
          out_len_nxt    = len_ext[POS_W-1:0];
          out_gap_nxt    = gs_ext[POS_W-1:0];
          state_nxt      = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      gs_r        <= '0;
      gl_r        <= CAP_L;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      gs_r        <= gs_nxt;
      gl_r        <= gl_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r        <= cmd_nxt;
    pos_r        <= pos_nxt;
    ch_r         <= ch_nxt;
    dir_left_r   <= dir_left_nxt;
    stat_r       <= stat_nxt;
    cout_r       <= cout_nxt;
    out_status_r <= out_status_nxt;
    out_char_r   <= out_char_nxt;
    out_len_r    <= out_len_nxt;
    out_gap_r    <= out_gap_nxt;
  end

  gbl_ram #(
    .DEPTH (CAPACITY),
    .AW    (AW)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign out_valid        = out_valid_r;
  assign out_status       = out_status_r;
  assign out_char_out     = out_char_r;
  assign out_line_length  = out_len_r;
  assign out_gap_position = out_gap_r;

endmodule

`default_nettype wire

>>> tb/gbl_line_shadow_pkg.sv
// Shadow copy of the gap buffer line and the queue of results it still awaits.
// Depends on gbl_pkg for the command and status codes and the field widths.
`timescale 1ns / 1ps

package gbl_line_shadow_pkg;
  import gbl_pkg::*;

  localparam int LINE_CAP     = 256;
  localparam int REPORT_LIMIT = 10;

  typedef struct packed {
    status_t           status;
    logic [CHAR_W-1:0] char_out;
    logic [POS_W-1:0]  length;
    logic [POS_W-1:0]  gap_pos;
  } line_result_t;

  class line_shadow;
    logic [CHAR_W-1:0] text [LINE_CAP];
    int unsigned       gap_start;
    int unsigned       gap_len;
    line_result_t      awaited_results[$];
    int                mismatches;
    int                requests;
    int                results;
    int                status_seen [4];
    int unsigned       longest;

    function new();
      foreach (text[i]) text[i] = '0;
      foreach (status_seen[i]) status_seen[i] = 0;
      gap_start  = 0;
      gap_len    = LINE_CAP;
      mismatches = 0;
      requests   = 0;
      results    = 0;
      longest    = 0;
    endfunction

    function int unsigned line_length();
      return LINE_CAP - gap_len;
    endfunction

    function int unsigned cursor();
      return gap_start;
    endfunction

    function int pending();
      return awaited_results.size();
    endfunction

    function logic [CHAR_W-1:0] byte_at(int unsigned idx);
      return (idx < LINE_CAP) ? text[idx] : '0;
    endfunction

    // Copy bytes across the gap one position at a time.
    function void move_gap_to(int unsigned pos);
      while (gap_start > pos) begin
        if (gap_start + gap_len - 1 < LINE_CAP)
          text[gap_start + gap_len - 1] = byte_at(gap_start - 1);
        gap_start--;
      end
      while (gap_start < pos) begin
        if (gap_start < LINE_CAP)
          text[gap_start] = byte_at(gap_start + gap_len);
        gap_start++;
      end
    endfunction

    function void apply_request(cmd_t cmd, logic [POS_W-1:0] pos_in, logic [CHAR_W-1:0] ch);
      int unsigned  pos;
      int unsigned  len;
      line_result_t r;
      pos        = pos_in;
      len        = line_length();
      r.status   = ST_OK;
      r.char_out = '0;
      case (cmd)
        CMD_INSERT: begin
          if (pos > len) r.status = ST_RANGE;
          else if (gap_len == 0) r.status = ST_FULL;
          else begin
            move_gap_to(pos);
            text[gap_start] = ch;
            gap_start++;
            gap_len--;
          end
        end
        CMD_BACKSPACE: begin
          if (pos > len) r.status = ST_RANGE;
          else if (pos == 0) r.status = ST_NOTHING;
          else begin
            move_gap_to(pos);
            gap_start--;
            gap_len++;
          end
        end
        CMD_READ: begin
          if (pos >= len) r.status = ST_RANGE;
          else if (pos < gap_start) r.char_out = byte_at(pos);
          else r.char_out = byte_at(pos + gap_len);
        end
        default: begin
          gap_start = 0;
          gap_len   = LINE_CAP;
        end
      endcase
      r.length  = POS_W'(LINE_CAP - gap_len);
      r.gap_pos = POS_W'(gap_start);
      awaited_results.push_back(r);
      requests++;
      status_seen[r.status]++;
      if (line_length() > longest) longest = line_length();
    endfunction

    function void compare_result(logic [STAT_W-1:0] st, logic [CHAR_W-1:0] ch,
                                 logic [POS_W-1:0] len, logic [POS_W-1:0] gap);
      line_result_t want;
      results++;
      if (awaited_results.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_LIMIT)
          $display("unexpected result: status %0d char %h length %0d gap %0d",
                   st, ch, len, gap);
        return;
      end
      want = awaited_results.pop_front();
      if (want.status !== st || want.char_out !== ch || want.length !== len ||
          want.gap_pos !== gap) begin
        mismatches++;
        if (mismatches <= REPORT_LIMIT)
          $display("result %0d: expected status %0d char %h length %0d gap %0d, got status %0d char %h length %0d gap %0d",
                   results, want.status, want.char_out, want.length, want.gap_pos,
                   st, ch, len, gap);
      end
    endfunction
  endclass

endpackage

>>> tb/testbench.sv
// Top of the line store testbench: clock, reset, request driver, result sink and monitor.
// Depends on gbl_pkg, gbl_line_shadow_pkg and the gap_buffer_line_store RTL.
`timescale 1ns / 1ps

module testbench;
  import gbl_pkg::*;
  import gbl_line_shadow_pkg::*;

  localparam int CLK_HALF     = 5;
  localparam int RESET_CYCLES = 8;
  localparam int LIMIT_CYCLES = 4_000_000;
  localparam int DRAIN_CYCLES = 32;
  localparam int IDLE_PCT     = 27;
  localparam int BLOCK_ITEMS  = 102;
  localparam int HOLD_AT      = 300;
  localparam int HOLD_CYCLES  = 400;
  localparam int CALM_FROM    = 520;
  localparam int CALM_TO      = 720;
  localparam int BLOCKS       = 13;

  typedef enum {MODE_MIX, MODE_FILL, MODE_DRAIN} edit_mode_t;

  localparam edit_mode_t PLAN [BLOCKS] = '{
    MODE_MIX, MODE_FILL, MODE_FILL, MODE_FILL, MODE_FILL, MODE_FILL, MODE_MIX,
    MODE_DRAIN, MODE_DRAIN, MODE_DRAIN, MODE_MIX, MODE_FILL, MODE_DRAIN
  };

  logic              clk         = 1'b0;
  logic              rst_n       = 1'b0;
  logic              in_valid    = 1'b0;
  logic              in_stall;
  logic [CMD_W-1:0]  in_command  = '0;
  logic [POS_W-1:0]  in_position = '0;
  logic [CHAR_W-1:0] in_char_in  = '0;
  logic              out_valid;
  logic              out_stall   = 1'b0;
  logic [STAT_W-1:0] out_status;
  logic [CHAR_W-1:0] out_char_out;
  logic [POS_W-1:0]  out_line_length;
  logic [POS_W-1:0]  out_gap_position;

  line_shadow shadow;
  int         sent_count = 0;
  int         hold_left  = 0;
  bit         hold_done  = 1'b0;

  gap_buffer_line_store #(.CAPACITY(LINE_CAP)) i_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_command       (in_command),
    .in_position      (in_position),
    .in_char_in       (in_char_in),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_status       (out_status),
    .out_char_out     (out_char_out),
    .out_line_length  (out_line_length),
    .out_gap_position (out_gap_position)
  );

  initial begin
    forever #CLK_HALF clk = ~clk;
  end

  initial begin
    for (int cyc = 0; cyc < LIMIT_CYCLES; cyc++) @(posedge clk);
    $display("timeout after %0d cycles, %0d results still awaited",
             LIMIT_CYCLES, shadow.pending());
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // Result sink: one long hold-off after HOLD_AT requests, a calm window, else random stalls.
  always @(negedge clk) begin
    if (!hold_done && sent_count >= HOLD_AT) begin
      hold_left = HOLD_CYCLES;
      hold_done = 1'b1;
    end
    if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left--;
    end else if (sent_count >= CALM_FROM && sent_count < CALM_TO) begin
      out_stall <= 1'b0;
    end else begin
      out_stall <= ($urandom_range(99) < IDLE_PCT);
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall)
        shadow.apply_request(cmd_t'(in_command), in_position, in_char_in);
      if (out_valid && !out_stall)
        shadow.compare_result(out_status, out_char_out, out_line_length, out_gap_position);
    end
  end

  task automatic send_request(input cmd_t cmd, input int unsigned pos, input int unsigned ch);
    bit may_idle;
    may_idle = !(sent_count >= CALM_FROM && sent_count < CALM_TO);
    while (may_idle && $urandom_range(99) < IDLE_PCT) begin
      in_valid    <= 1'b0;
      in_command  <= CMD_W'($urandom);
      in_position <= POS_W'($urandom);
      in_char_in  <= CHAR_W'($urandom);
      @(negedge clk);
    end
    in_valid    <= 1'b1;
    in_command  <= cmd;
    in_position <= POS_W'(pos);
    in_char_in  <= CHAR_W'(ch);
    do @(posedge clk); while (in_stall);
    sent_count++;
    @(negedge clk);
  endtask

  initial begin
    int unsigned len;
    int unsigned cur;
    int unsigned pos;
    int unsigned roll;
    int unsigned proll;
    int          near;
    cmd_t        cmd;

    shadow = new();
    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed: empty line, edges of the line, gap moves both ways, clear.
    send_request(CMD_READ,      0,   8'h11);
    send_request(CMD_BACKSPACE, 0,   8'h22);
    send_request(CMD_BACKSPACE, 1,   8'h33);
    send_request(CMD_INSERT,    1,   8'h44);
    send_request(CMD_INSERT,    0,   8'h00);
    send_request(CMD_INSERT,    1,   8'hFF);
    send_request(CMD_INSERT,    1,   8'hA5);
    send_request(CMD_INSERT,    0,   8'h5A);
    send_request(CMD_READ,      3,   8'h00);
    send_request(CMD_READ,      0,   8'hFF);
    send_request(CMD_READ,      2,   8'h00);
    send_request(CMD_READ,      4,   8'h00);
    send_request(CMD_READ,      511, 8'hFF);
    send_request(CMD_INSERT,    511, 8'hFF);
    send_request(CMD_INSERT,    4,   8'h7E);
    send_request(CMD_BACKSPACE, 5,   8'h00);
    send_request(CMD_BACKSPACE, 1,   8'h00);
    send_request(CMD_READ,      1,   8'h00);
    send_request(CMD_BACKSPACE, 0,   8'hFF);
    send_request(CMD_BACKSPACE, 511, 8'hFF);
    send_request(CMD_CLEAR,     511, 8'hFF);
    send_request(CMD_READ,      0,   8'h00);
    send_request(CMD_INSERT,    0,   8'h80);
    send_request(CMD_CLEAR,     0,   8'h00);

    // Random edit sessions: fill the line to capacity, mix, drain it again.
    for (int b = 0; b < BLOCKS; b++) begin
      for (int k = 0; k < BLOCK_ITEMS; k++) begin
        len  = shadow.line_length();
        cur  = shadow.cursor();
        roll = $urandom_range(99);
        case (PLAN[b])
          MODE_FILL: begin
            if (roll < 80) cmd = CMD_INSERT;
            else if (roll < 88) cmd = CMD_BACKSPACE;
            else cmd = CMD_READ;
          end
          MODE_DRAIN: begin
            if (roll < 20) cmd = CMD_INSERT;
            else if (roll < 80) cmd = CMD_BACKSPACE;
            else cmd = CMD_READ;
          end
          default: begin
            if (roll < 40) cmd = CMD_INSERT;
            else if (roll < 70) cmd = CMD_BACKSPACE;
            else if (roll < 98) cmd = CMD_READ;
            else cmd = CMD_CLEAR;
          end
        endcase
        proll = $urandom_range(99);
        if (proll < 70) begin
          // Stay near the cursor, as typical editing does.
          near = int'(cur) + int'($urandom_range(8)) - 4;
          if (near < 0) near = 0;
          if (near > int'(len)) near = int'(len);
          pos = unsigned'(near);
        end else if (proll < 85) begin
          pos = $urandom_range(len);
        end else if (proll < 90) begin
          pos = $urandom_range(1) ? len : 0;
        end else begin
          pos = $urandom_range(511, len + 1);
        end
        send_request(cmd, pos, $urandom_range(255));
      end
    end
    in_valid <= 1'b0;

    while (shadow.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("covered %0d requests, %0d results:", shadow.requests, shadow.results,
             " %0d ok, %0d full, %0d out of range, %0d nothing before",
             shadow.status_seen[ST_OK], shadow.status_seen[ST_FULL],
             shadow.status_seen[ST_RANGE], shadow.status_seen[ST_NOTHING]);
    $display("longest line %0d of %0d bytes, %0d mismatches",
             shadow.longest, LINE_CAP, shadow.mismatches);
    if (shadow.mismatches == 0 && shadow.pending() == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
